>>> sv/gn3_pkg.sv
package gn3_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned FadeW  = FracW + 1;
  localparam int unsigned CrnW   = FracW + 2;
  localparam int unsigned GradW  = 20;
  localparam int unsigned LprodW = 39;
  localparam int unsigned OutW   = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [IdxW-1:0]          idx;
    logic [IdxW-1:0]          val;
  } item_t;

  function automatic logic signed [GradW-1:0] grad(
    input logic [3:0]              h,
    input logic signed [CrnW-1:0]  x,
    input logic signed [CrnW-1:0]  y,
    input logic signed [CrnW-1:0]  z
  );
    logic signed [GradW-1:0] u;
    logic signed [GradW-1:0] v;
    u = (h < 4'd8) ? GradW'(x) : GradW'(y);
    if (h < 4'd4) begin
      v = GradW'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = GradW'(x);
    end else begin
      v = GradW'(z);
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic signed [LprodW-1:0] lerp_mul(
    input logic [FadeW-1:0]        t,
    input logic signed [GradW-1:0] a,
    input logic signed [GradW-1:0] b
  );
    logic signed [GradW:0] diff;
    diff = (GradW+1)'(b) - (GradW+1)'(a);
    return LprodW'($signed({1'b0, t})) * LprodW'(diff);
  endfunction

  function automatic logic signed [GradW-1:0] lerp_fin(
    input logic signed [GradW-1:0]  a,
    input logic signed [LprodW-1:0] p
  );
    logic signed [LprodW-1:0] r;
    r = (p + LprodW'(32768)) >>> FracW;
    return a + GradW'(r);
  endfunction

endpackage

>>> sv/gn3_ram.sv
module gn3_ram (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_a_i,
  input  logic [7:0] raddr_b_i,
  output logic [7:0] rdata_a_o,
  output logic [7:0] rdata_b_o
);
  logic [7:0] mem_q [256];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end
endmodule

>>> sv/gn3_front.sv
module gn3_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cmd_i,
  input  logic [31:0]   coord_x_i,
  input  logic [31:0]   coord_y_i,
  input  logic [31:0]   coord_z_i,
  input  logic [7:0]    entry_index_i,
  input  logic [7:0]    entry_value_i,
  output logic          head_valid_o,
  output gn3_pkg::item_t head_o,
  input  logic          pop_i
);
  import gn3_pkg::*;

  item_t                buf_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FifoPtrW:0]    cnt_q, cnt_d;
  logic                 push;
  logic                 pop;
  item_t                word;

  always_comb begin
    word.op  = cmd_i ? OP_EVAL : OP_WRITE;
    word.x   = coord_x_i;
    word.y   = coord_y_i;
    word.z   = coord_z_i;
    word.idx = entry_index_i;
    word.val = entry_value_i;
  end

  assign in_ready_o   = (cnt_q != (FifoPtrW+1)'(FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = buf_q[rd_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = pop_i & head_valid_o;
  assign wr_d = push ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d = cnt_q + (FifoPtrW+1)'(push) - (FifoPtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

>>> sv/gn3_fade.sv
module gn3_fade (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [gn3_pkg::FracW-1:0]     t_i,
  output logic [gn3_pkg::FadeW-1:0]     fade_o
);
  import gn3_pkg::*;

  logic signed [CrnW-1:0] t0, t1_q, t2_q;
  logic signed [21:0]     a0;
  logic signed [39:0]     p1_q;
  logic signed [35:0]     p2_q;
  logic signed [21:0]     b2_q, b3_q, b_d;
  logic signed [CrnW-1:0] c2_q, c_d, d4;
  logic signed [35:0]     cp3_q;
  logic signed [39:0]     pr4_q, r5;
  logic [FadeW-1:0]       f_d;

  assign t0 = $signed({2'b00, t_i});
  assign a0 = 22'(t0) * 22'sd6 - 22'sd983040;
  assign b_d = 22'((p1_q + 40'sd32768) >>> FracW) + 22'sd655360;
  assign c_d = CrnW'((p2_q + 36'sd32768) >>> FracW);
  assign d4  = CrnW'((cp3_q + 36'sd32768) >>> FracW);
  assign r5  = (pr4_q + 40'sd32768) >>> FracW;

  always_comb begin
    if (r5 < 0) begin
      f_d = '0;
    end else if (r5 > 40'sd65536) begin
      f_d = FadeW'(65536);
    end else begin
      f_d = FadeW'(r5);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= 40'(t0) * 40'(a0);
      p2_q   <= 36'(t0) * 36'(t0);
      t1_q   <= t0;
      b2_q   <= b_d;
      c2_q   <= c_d;
      t2_q   <= t1_q;
      cp3_q  <= 36'(c2_q) * 36'(t2_q);
      b3_q   <= b2_q;
      pr4_q  <= 40'(d4) * 40'(b3_q);
      fade_o <= f_d;
    end
  end
endmodule

>>> sv/gn3_back.sv
module gn3_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  gn3_pkg::item_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    noise_value_o
);
  import gn3_pkg::*;

  localparam int unsigned NStg = 12;

  logic [NStg:1] v_q;
  logic          adv, issue_eval, issue_wr;

  logic [7:0] t0a, t0b, t1a, t1b, t2a, t2b;
  logic [7:0] h3 [8];
  logic [7:0] cy1_q, cz1_q, cz2_q, a1, b1, aa2, ab2, ba2, bb2;
  logic [FracW-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, x3_q, y3_q, z3_q;
  logic [FadeW-1:0] u5, v5, w5, v6_q, w6_q, v7_q, w7_q, w8_q, w9_q;
  logic signed [CrnW-1:0] cx0, cx1, cy0, cyn, cz0, czn;
  logic signed [GradW-1:0] g4_q [8];
  logic signed [GradW-1:0] g5_q [8];
  logic signed [GradW-1:0] la6_q [4];
  logic signed [LprodW-1:0] lp6_q [4];
  logic signed [GradW-1:0] l7_q [4];
  logic signed [GradW-1:0] ma8_q [2];
  logic signed [LprodW-1:0] mp8_q [2];
  logic signed [GradW-1:0] m9_q [2];
  logic signed [GradW-1:0] na10_q, n11_q;
  logic signed [LprodW-1:0] np10_q;
  logic signed [21:0] s11;
  logic [21:0] r11;
  logic [OutW-1:0] o_d;

  // output register doubles as last stage; whole pipe freezes behind it
  assign adv = !v_q[NStg] || out_ready_i;
  assign issue_eval = head_valid_i && (head_i.op == OP_EVAL) && adv;
  // a table write waits until no point still has reads pending
  assign issue_wr = head_valid_i && (head_i.op == OP_WRITE) && !v_q[1] && !v_q[2];
  assign pop_o = issue_eval || issue_wr;
  assign out_valid_o = v_q[NStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStg-1:1], issue_eval};
    end
  end

  gn3_ram u_ram0 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(head_i.x[23:16]), .raddr_b_i(head_i.x[23:16] + 8'd1),
    .rdata_a_o(t0a), .rdata_b_o(t0b));

  assign a1 = t0a + cy1_q;
  assign b1 = t0b + cy1_q;

  gn3_ram u_ram1 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(a1), .raddr_b_i(a1 + 8'd1), .rdata_a_o(t1a), .rdata_b_o(t1b));
  gn3_ram u_ram2 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(b1), .raddr_b_i(b1 + 8'd1), .rdata_a_o(t2a), .rdata_b_o(t2b));

  assign aa2 = t1a + cz2_q;
  assign ab2 = t1b + cz2_q;
  assign ba2 = t2a + cz2_q;
  assign bb2 = t2b + cz2_q;

  // hash order: AA, BA, AB, BB, then the same four at z+1
  gn3_ram u_ram3 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(aa2), .raddr_b_i(aa2 + 8'd1), .rdata_a_o(h3[0]), .rdata_b_o(h3[4]));
  gn3_ram u_ram4 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(ba2), .raddr_b_i(ba2 + 8'd1), .rdata_a_o(h3[1]), .rdata_b_o(h3[5]));
  gn3_ram u_ram5 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(ab2), .raddr_b_i(ab2 + 8'd1), .rdata_a_o(h3[2]), .rdata_b_o(h3[6]));
  gn3_ram u_ram6 (.clk_i, .we_i(issue_wr), .waddr_i(head_i.idx), .wdata_i(head_i.val),
    .re_i(adv), .raddr_a_i(bb2), .raddr_b_i(bb2 + 8'd1), .rdata_a_o(h3[3]), .rdata_b_o(h3[7]));

  gn3_fade u_fade_x (.clk_i, .en_i(adv), .t_i(head_i.x[FracW-1:0]), .fade_o(u5));
  gn3_fade u_fade_y (.clk_i, .en_i(adv), .t_i(head_i.y[FracW-1:0]), .fade_o(v5));
  gn3_fade u_fade_z (.clk_i, .en_i(adv), .t_i(head_i.z[FracW-1:0]), .fade_o(w5));

  assign cx0 = $signed({2'b00, x3_q});
  assign cy0 = $signed({2'b00, y3_q});
  assign cz0 = $signed({2'b00, z3_q});
  assign cx1 = cx0 - CrnW'(65536);
  assign cyn = cy0 - CrnW'(65536);
  assign czn = cz0 - CrnW'(65536);

  assign s11 = 22'(n11_q) + 22'sd65536;
  assign r11 = (s11 < 0) ? '0 : (22'(s11) + 22'd1) >> 1;
  assign o_d = (r11 > 22'd65535) ? 16'hFFFF : OutW'(r11);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cy1_q <= head_i.y[23:16];
      cz1_q <= head_i.z[23:16];
      x1_q  <= head_i.x[FracW-1:0];
      y1_q  <= head_i.y[FracW-1:0];
      z1_q  <= head_i.z[FracW-1:0];
      cz2_q <= cz1_q;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      x3_q  <= x2_q;
      y3_q  <= y2_q;
      z3_q  <= z2_q;
      g4_q[0] <= grad(h3[0][3:0], cx0, cy0, cz0);
      g4_q[1] <= grad(h3[1][3:0], cx1, cy0, cz0);
      g4_q[2] <= grad(h3[2][3:0], cx0, cyn, cz0);
      g4_q[3] <= grad(h3[3][3:0], cx1, cyn, cz0);
      g4_q[4] <= grad(h3[4][3:0], cx0, cy0, czn);
      g4_q[5] <= grad(h3[5][3:0], cx1, cy0, czn);
      g4_q[6] <= grad(h3[6][3:0], cx0, cyn, czn);
      g4_q[7] <= grad(h3[7][3:0], cx1, cyn, czn);
      // gradients wait one stage for the fade
      for (int k = 0; k < 8; k++) begin
        g5_q[k] <= g4_q[k];
      end
      for (int i = 0; i < 4; i++) begin
        la6_q[i] <= g5_q[2*i];
        lp6_q[i] <= lerp_mul(u5, g5_q[2*i], g5_q[2*i+1]);
        l7_q[i]  <= lerp_fin(la6_q[i], lp6_q[i]);
      end
      v6_q <= v5;
      w6_q <= w5;
      v7_q <= v6_q;
      w7_q <= w6_q;
      for (int j = 0; j < 2; j++) begin
        ma8_q[j] <= l7_q[2*j];
        mp8_q[j] <= lerp_mul(v7_q, l7_q[2*j], l7_q[2*j+1]);
        m9_q[j]  <= lerp_fin(ma8_q[j], mp8_q[j]);
      end
      w8_q   <= w7_q;
      w9_q   <= w8_q;
      na10_q <= m9_q[0];
      np10_q <= lerp_mul(w9_q, m9_q[0], m9_q[1]);
      n11_q  <= lerp_fin(na10_q, np10_q);
      noise_value_o <= o_d;
    end
  end
endmodule

>>> sv/gradient_noise_3d.sv
// Improved 3D gradient noise. Table writes (cmd 0) and noise points (cmd 1)
// enter a four-word queue; behind it a 12-stage pipeline takes one point per
// cycle while the result word is not held off, so points follow one another
// without waiting for earlier results. The pipeline length is set by the
// three dependent table lookups and the fade and lerp multiplier chains. A
// table write waits at the queue head until no point still has lookups
// pending, and longer while the result word is held off. The table is held
// in seven identical copies so that all fourteen lookups of a point fit in
// one pass.
module gradient_noise_3d (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  entry_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] noise_value_o
);
  import gn3_pkg::*;

  logic  head_valid;
  logic  pop;
  item_t head;

  gn3_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .coord_x_i, .coord_y_i,
    .coord_z_i, .entry_index_i, .entry_value_i,
    .head_valid_o(head_valid), .head_o(head), .pop_i(pop)
  );

  gn3_back u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .noise_value_o
  );
endmodule

>>> sv/gn3_checker.sv
module gn3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] noise_value_o
);
  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("result word dropped or changed while stalled");

  a_rst_clear: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // no result can reach the output sooner than the pipeline depth after reset
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rst_ni, 11))
    else $error("result appeared too soon after reset");
endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .noise_value_o
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gn3_pkg::*;

  localparam longint One       = 64'sd65536;
  localparam int     CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_e         cmd = OP_WRITE;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic [31:0] coord_z = '0;
  logic [7:0]  entry_index = '0;
  logic [7:0]  entry_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] noise_value;

  logic [7:0]  perm_lut [256];
  logic [15:0] noise_expected [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold = 0;

  gradient_noise_3d dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .coord_x_i     (coord_x),
    .coord_y_i     (coord_y),
    .coord_z_i     (coord_z),
    .entry_index_i (entry_index),
    .entry_value_i (entry_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .noise_value_o (noise_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // fixed-point multiply, rounding half up
  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint fade(longint t);
    longint a, b, c, d, r;
    a = 6 * t - 15 * One;
    b = fx_mul(t, a) + 10 * One;
    c = fx_mul(t, t);
    d = fx_mul(c, t);
    r = fx_mul(d, b);
    if (r < 0) r = 0;
    if (r > One) r = One;
    return r;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + fx_mul(t, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic [7:0] lut(longint i);
    return perm_lut[i & 255];
  endfunction

  function automatic logic [15:0] noise_of(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    longint x, y, z, u, v, w, a, b, aa, ab, ba, bb, n, s;
    x = px[15:0];
    y = py[15:0];
    z = pz[15:0];
    u = fade(x);
    v = fade(y);
    w = fade(z);
    a  = longint'(lut(px[23:16])) + py[23:16];
    aa = longint'(lut(a)) + pz[23:16];
    ab = longint'(lut(a + 1)) + pz[23:16];
    b  = longint'(lut(px[23:16] + 1)) + py[23:16];
    ba = longint'(lut(b)) + pz[23:16];
    bb = longint'(lut(b + 1)) + pz[23:16];
    n = blend(w,
          blend(v,
            blend(u, corner_dot(lut(aa), x, y, z),
                     corner_dot(lut(ba), x - One, y, z)),
            blend(u, corner_dot(lut(ab), x, y - One, z),
                     corner_dot(lut(bb), x - One, y - One, z))),
          blend(v,
            blend(u, corner_dot(lut(aa + 1), x, y, z - One),
                     corner_dot(lut(ba + 1), x - One, y, z - One)),
            blend(u, corner_dot(lut(ab + 1), x, y - One, z - One),
                     corner_dot(lut(bb + 1), x - One, y - One, z - One))));
    s = n + One;
    if (s < 0) s = 0;
    s = (s + 1) >>> 1;
    if (s > 65535) s = 65535;
    return s[15:0];
  endfunction

  // offer one word, hold until taken, then update the prediction
  task automatic send_word(op_e op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [7:0] idx, logic [7:0] val);
    in_valid    <= 1'b1;
    cmd         <= op;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE) perm_lut[idx] = val;
    else noise_expected.push_back(noise_of(x, y, z));
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(OP_EVAL, x, y, z, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // shuffled permutation, every entry written before any lookup
  task automatic test_table_load();
    logic [7:0] p [256];
    logic [7:0] t;
    int j;
    for (int i = 0; i < 256; i++) p[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      t = p[i]; p[i] = p[j]; p[j] = t;
    end
    for (int i = 0; i < 256; i++) send_word(OP_WRITE, $urandom, $urandom, $urandom, 8'(i), p[i]);
  endtask

  task automatic test_directed();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'h0000_ffff, 32'hffff_0000);
    send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_point(32'h00ff_4000, 32'hff00_c000, 32'h0);  // cell 255 wraps to 0
    send_point(32'h0001_2345, 32'h0, 32'h0);          // 1D form
    send_point(32'h0003_1234, 32'hfffd_abcd, 32'h0);  // 2D form
    send_point(32'h0000_0001, 32'h0000_fffe, 32'hffff_ffff);
    send_point(32'h8000_ffff, 32'h7fff_0001, 32'h5555_aaaa);
    // table writes with ignored coordinates, including index 255 and extremes
    send_word(OP_WRITE, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 8'd255, perm_lut[0]);
    send_word(OP_WRITE, 32'h0, 32'h0, 32'h0, 8'd0, 8'd255);
    send_word(OP_WRITE, 32'h0, 32'h0, 32'h0, 8'd128, 8'd0);
    send_point(32'h00ff_ffff, 32'h00ff_ffff, 32'h00ff_ffff);
    send_point(32'h0080_0000, 32'h0000_0000, 32'h00ff_8000);
    drain();
  endtask

  task automatic test_random(int count);
    logic [31:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        send_word(OP_WRITE, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
      end else begin
        x = $urandom; y = $urandom; z = $urandom;
        case ($urandom_range(3))
          0: z = '0;
          1: begin x = {{8{x[31]}}, x[23:0]}; y = {{8{y[31]}}, y[23:0]}; end
          default: ;
        endcase
        send_point(x, y, z);
      end
    end
  endtask

  // long receiver hold while points keep coming, so the input stalls
  task automatic test_backpressure();
    recv_hold = 200;
    for (int i = 0; i < 40; i++) send_point($urandom, $urandom, $urandom);
    drain();
  endtask

  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, noise_value);
        errors++;
      end else if (noise_value !== noise_expected[0]) begin
        $display("%0t: noise_value expected %h actual %h", $time, noise_expected[0], noise_value);
        errors++;
        void'(noise_expected.pop_front());
      end else begin
        void'(noise_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed();
    send_idle_pct = 34; recv_idle_pct = 87;
    test_random(120);
    test_backpressure();
    drain();
    send_idle_pct = 87; recv_idle_pct = 34;
    test_random(130);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(190);
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && noise_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
